/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the color ramp checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define PLCR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define PLCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/plcr_pkg.sv */
// ----------------------------------------------------------------------------
// plcr_pkg
// Types, codes and helpers shared by the piecewise-linear color ramp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package plcr_pkg;

  localparam int CHAN_W   = 16;
  localparam int NUM_CHAN = 3;
  localparam int CLR_W    = CHAN_W * NUM_CHAN;
  localparam int ENTRY_W  = CHAN_W + CLR_W;
  localparam int IDX_W    = 12;
  localparam int RS_W     = 13;
  localparam int FRAC_W   = 15;

  localparam int MAX_POINTS_DEFAULT = 8;

  // Iterative divider widths: product of two Q1.15 values over a Q1.15 span.
  localparam int DIV_NUM_W = 32;
  localparam int DIV_DEN_W = 16;

  localparam logic [CHAN_W-1:0] ONE_Q15         = 16'd32768;
  localparam logic [RS_W-1:0]   RAMP_SIZE_RESET = 13'd256;
  localparam logic [RS_W-1:0]   RAMP_SIZE_MIN   = 13'd2;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CHAN_W-1:0] point_position;
    logic [CHAN_W-1:0] point_red;
    logic [CHAN_W-1:0] point_green;
    logic [CHAN_W-1:0] point_blue;
    logic [IDX_W-1:0]  entry_index;
  } plcr_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
  } plcr_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POS_DIV,
    ST_SCAN,
    ST_SEG_START,
    ST_SEG_DIV
  } plcr_state_t;

  // Clamp a raw value to 1.0.
  function automatic logic [CHAN_W-1:0] sat_q15(input logic [CHAN_W-1:0] v);
    return (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

endpackage

/* rtl/core/plcr_ram.sv */
// ----------------------------------------------------------------------------
// plcr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plcr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/plcr_divider.sv */
// ----------------------------------------------------------------------------
// plcr_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plcr_divider import plcr_pkg::*; #(
  parameter int NUM_W = DIV_NUM_W,
  parameter int DEN_W = DIV_DEN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numerator,
  input  logic [DEN_W-1:0] denominator,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             running;
  logic [CNT_W-1:0] count;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic [DEN_W:0]   trial_sub;

  // Shift in the next numerator bit and subtract if the divisor fits.
  always_comb begin
    trial     = {rem, quo[NUM_W-1]};
    fits      = trial >= {1'b0, den};
    trial_sub = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= CNT_W'(NUM_W);
      end else if (running) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= numerator;
      rem <= '0;
      den <= denominator;
    end else if (running) begin
      quo <= {quo[NUM_W-2:0], fits};
      rem <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

/* rtl/core/piecewise_linear_color_ramp.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_color_ramp
// Color ramp generator over a small table of Q1.15 control points.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Commands enter on start while busy is low; each command returns exactly one
// result, shown on result for a single cycle with done high, and the receiver
// cannot stall it, so capture it on that cycle. Clear, append and any command
// that needs no table walk (empty-table query, unused mode) answer on the
// cycle after start and leave busy low, so a new command may follow at once.
// A query raises busy: a divider turns the index into a position, the point
// RAM is then read one entry per cycle, and a second divide pass (all three
// channels in parallel lanes) interpolates the color. Control points are to
// be appended by the user in ascending position order; the block itself does
// not enforce it. ramp_size is written over the cfg channel only while no
// command is in flight.

module piecewise_linear_color_ramp import plcr_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  plcr_req_t       request,
  output logic            done,
  output plcr_rsp_t       result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [RS_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  plcr_state_t       state;
  plcr_state_t       state_next;
  logic [CW-1:0]     point_count;
  logic [RS_W-1:0]   ramp_size;
  logic [CHAN_W-1:0] u_pos;
  logic [AW-1:0]     scan_idx;
  logic [CHAN_W-1:0] prev_pos;
  logic [CLR_W-1:0]  prev_color;
  logic [CHAN_W-1:0] seg_cl [NUM_CHAN];
  logic [CHAN_W-1:0] seg_diff [NUM_CHAN];
  logic [NUM_CHAN-1:0] seg_neg;
  logic [CHAN_W-1:0] seg_dl;
  logic [CHAN_W-1:0] seg_span;

  // --------------------------------------------------------------------------
  // Combinational signals
  // --------------------------------------------------------------------------
  logic              accept;
  logic              table_full;
  logic              query_go;
  logic              append_we;
  logic [RS_W-1:0]   rs_clamped;
  logic [RS_W-1:0]   rs_m1;
  logic [RS_W-1:0]   idx_clamped;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CHAN_W-1:0] rd_pos;
  logic [CLR_W-1:0]  rd_color;
  logic              scan_low;
  logic              scan_hit;
  logic              scan_last;
  logic              scan_more;
  logic              div_start;
  logic              div_sel_pos;
  logic [NUM_CHAN-1:0] div_done;
  logic [DIV_NUM_W-1:0] div_quo [NUM_CHAN];
  logic [CHAN_W-1:0] interp [NUM_CHAN];
  logic [CHAN_W-1:0] u_next;
  logic              rsp_load;
  plcr_rsp_t         rsp_next;

  // --------------------------------------------------------------------------
  // Command decode
  // --------------------------------------------------------------------------
  assign accept     = start && !busy;
  assign table_full = point_count == CW'(MAX_POINTS);
  assign query_go   = accept && (request.mode == MODE_QUERY) && (point_count != '0);
  assign append_we  = accept && (request.mode == MODE_APPEND) && !table_full;
  assign cfg_ready  = !busy;

  // Clamp ramp_size and the index, then form index * 1.0 for the divider.
  always_comb begin
    rs_clamped  = (ramp_size < RAMP_SIZE_MIN) ? RAMP_SIZE_MIN : ramp_size;
    rs_m1       = rs_clamped - RS_W'(1);
    idx_clamped = ({1'b0, request.entry_index} > rs_m1) ? rs_m1
                                                        : {1'b0, request.entry_index};
  end

  // --------------------------------------------------------------------------
  // Point table: position in the top field, then red, green, blue
  // --------------------------------------------------------------------------
  assign ram_wdata = {sat_q15(request.point_position), sat_q15(request.point_red),
                      sat_q15(request.point_green), sat_q15(request.point_blue)};

  plcr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_point_ram (
    .clk   (clk),
    .we    (append_we),
    .waddr (point_count[AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_pos   = ram_rdata[ENTRY_W-1 -: CHAN_W];
  assign rd_color = ram_rdata[CLR_W-1:0];

  // --------------------------------------------------------------------------
  // Table walk decisions
  // --------------------------------------------------------------------------
  // Below the first point the first color applies (covers the implicit point
  // at position zero). Otherwise look for prev <= u < current.
  always_comb begin
    scan_low  = (scan_idx == '0) && (u_pos < rd_pos);
    scan_hit  = (scan_idx != '0) && (prev_pos <= u_pos) && (u_pos < rd_pos);
    scan_last = (CW'(scan_idx) + CW'(1)) == point_count;
    scan_more = !scan_low && !scan_hit && !scan_last;
  end

  // --------------------------------------------------------------------------
  // Divider lanes: lane zero also does the position divide
  // --------------------------------------------------------------------------
  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
    logic [DIV_NUM_W-1:0] lane_num;
    logic [DIV_DEN_W-1:0] lane_den;

    always_comb begin
      if ((c == 0) && div_sel_pos) begin
        lane_num = DIV_NUM_W'({idx_clamped, {FRAC_W{1'b0}}});
        lane_den = DIV_DEN_W'(rs_m1);
      end else begin
        lane_num = DIV_NUM_W'(seg_diff[c]) * DIV_NUM_W'(seg_dl);
        lane_den = seg_span;
      end
    end

    plcr_divider #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (DIV_DEN_W)
    ) u_divider (
      .clk         (clk),
      .rst         (rst),
      .start       (div_start),
      .numerator   (lane_num),
      .denominator (lane_den),
      .done        (div_done[c]),
      .quotient    (div_quo[c])
    );

    // Quotient never exceeds the channel difference, so the low bits suffice.
    assign interp[c] = seg_neg[c] ? (seg_cl[c] - div_quo[c][CHAN_W-1:0])
                                  : (seg_cl[c] + div_quo[c][CHAN_W-1:0]);
  end

  assign u_next = (div_quo[0] > DIV_NUM_W'(ONE_Q15)) ? ONE_Q15
                                                     : div_quo[0][CHAN_W-1:0];

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (query_go) begin
          state_next = ST_POS_DIV;
        end
      end
      ST_POS_DIV: begin
        if (div_done[0]) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          state_next = ST_SEG_START;
        end else if (scan_low || scan_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_SEG_START: begin
        state_next = ST_SEG_DIV;
      end
      ST_SEG_DIV: begin
        if (&div_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // State outputs
  // --------------------------------------------------------------------------
  always_comb begin
    busy        = 1'b1;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    div_start   = 1'b0;
    div_sel_pos = 1'b0;
    case (state)
      ST_IDLE: begin
        busy        = 1'b0;
        div_sel_pos = 1'b1;
        div_start   = query_go;
      end
      ST_POS_DIV: begin
        // Fetch point zero as the position settles.
        ram_re = div_done[0];
      end
      ST_SCAN: begin
        ram_re    = scan_more;
        ram_raddr = scan_idx + AW'(1);
      end
      ST_SEG_START: begin
        div_start = 1'b1;
      end
      ST_SEG_DIV: begin
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Result selection
  // --------------------------------------------------------------------------
  always_comb begin
    rsp_load = 1'b0;
    rsp_next = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (request.mode)
            MODE_CLEAR: begin
              rsp_load = 1'b1;
            end
            MODE_APPEND: begin
              rsp_load        = 1'b1;
              rsp_next.status = table_full ? STATUS_FULL : STATUS_OK;
            end
            MODE_QUERY: begin
              // An empty table answers at once; otherwise the walk answers.
              rsp_load        = point_count == '0;
              rsp_next.status = STATUS_EMPTY;
            end
            default: begin
              rsp_load = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_low || (!scan_hit && scan_last)) begin
          rsp_load           = 1'b1;
          rsp_next.status    = STATUS_OK;
          rsp_next.out_red   = rd_color[CLR_W-1 -: CHAN_W];
          rsp_next.out_green = rd_color[CLR_W-CHAN_W-1 -: CHAN_W];
          rsp_next.out_blue  = rd_color[CHAN_W-1:0];
        end
      end
      ST_SEG_DIV: begin
        if (&div_done) begin
          rsp_load           = 1'b1;
          rsp_next.status    = STATUS_OK;
          rsp_next.out_red   = interp[0];
          rsp_next.out_green = interp[1];
          rsp_next.out_blue  = interp[2];
        end
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      point_count <= '0;
      ramp_size   <= RAMP_SIZE_RESET;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= rsp_load;
      if (cfg_valid && cfg_ready) begin
        ramp_size <= cfg_data;
      end
      if (accept && (request.mode == MODE_CLEAR)) begin
        point_count <= '0;
      end else if (append_we) begin
        point_count <= point_count + CW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      result <= rsp_next;
    end
    // Latch the position and restart the walk at point zero.
    if ((state == ST_POS_DIV) && div_done[0]) begin
      u_pos    <= u_next;
      scan_idx <= '0;
    end
    if (state == ST_SCAN) begin
      if (scan_more) begin
        scan_idx   <= scan_idx + AW'(1);
        prev_pos   <= rd_pos;
        prev_color <= rd_color;
      end
      // Hold the segment: left color, sign and size of the step per channel.
      if (scan_hit) begin
        seg_dl   <= u_pos - prev_pos;
        seg_span <= rd_pos - prev_pos;
        for (int c = 0; c < NUM_CHAN; c++) begin
          seg_cl[c]   <= prev_color[CLR_W-1-CHAN_W*c -: CHAN_W];
          seg_neg[c]  <= rd_color[CLR_W-1-CHAN_W*c -: CHAN_W]
                         < prev_color[CLR_W-1-CHAN_W*c -: CHAN_W];
          seg_diff[c] <= (rd_color[CLR_W-1-CHAN_W*c -: CHAN_W]
                          < prev_color[CLR_W-1-CHAN_W*c -: CHAN_W])
                         ? prev_color[CLR_W-1-CHAN_W*c -: CHAN_W]
                           - rd_color[CLR_W-1-CHAN_W*c -: CHAN_W]
                         : rd_color[CLR_W-1-CHAN_W*c -: CHAN_W]
                           - prev_color[CLR_W-1-CHAN_W*c -: CHAN_W];
        end
      end
    end
  end

endmodule

/* rtl/core/plcr_checker.sv */
// ----------------------------------------------------------------------------
// plcr_checker
// Port-level checks on command and result timing of the color ramp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module plcr_checker import plcr_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input logic      done,
  input plcr_rsp_t result
);

  logic colored_error;

  // Flag a non-ok status that still carries a color.
  assign colored_error = (result.status != STATUS_OK)
                         && ((result.out_red != '0) || (result.out_green != '0)
                             || (result.out_blue != '0));

  // An accepted command either answers next cycle or holds busy.
  `PLCR_ASSERT(a_accept_progress, clk, rst, start && !busy |=> done || busy, "command lost")

  // No result while a query is still in flight.
  `PLCR_ASSERT(a_no_done_busy, clk, rst, busy |-> !done, "result during busy")

  // Busy drops only together with the query's result.
  `PLCR_ASSERT(a_busy_ends_done, clk, rst, !$past(rst) && $fell(busy) |-> done, "query ended without result")

  // Error results carry zero colors.
  `PLCR_ASSERT_ALWAYS(a_err_zero, clk, !(done && colored_error), "error result with color")

endmodule

bind piecewise_linear_color_ramp plcr_checker u_plcr_checker (.*);

/* test/tb_piecewise_linear_color_ramp.sv */
// ----------------------------------------------------------------------------
// tb_piecewise_linear_color_ramp
// Self-checking bench for the color ramp: a short table of hand-picked
// commands, then random clear / append / query sequences over several ramp
// sizes, each result compared field by field with its typed expectation or an in-bench prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_piecewise_linear_color_ramp;
  import plcr_pkg::*;

  localparam int          PT_DEPTH    = MAX_POINTS_DEFAULT;
  localparam logic [1:0]  MODE_SPARE  = 2'd3;
  localparam int          RAND_ITEMS  = 750;
  // Watchdog limit for about 800 commands, with a wide margin over their run time.
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          TAIL_CYCLES = 120;
  localparam int unsigned UNIT        = 32768;
  localparam bit          FIXED       = 1'b1;
  localparam bit          CALC        = 1'b0;

  // One command plus, where it is obvious, the result it must give.
  typedef struct packed {
    plcr_req_t req;
    bit        fixed;
    plcr_rsp_t rsp;
  } stim_row_t;

  logic            clk;
  logic            rst;
  logic            start;
  logic            busy;
  plcr_req_t       request;
  logic            done;
  plcr_rsp_t       result;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [RS_W-1:0] cfg_data;

  // Travel alongside request so the monitor knows which rows carry a typed
  // expectation.
  bit              req_fixed;
  plcr_rsp_t       req_fixed_rsp;

  // Shadow copy of the point table and the ramp size register.
  logic [CHAN_W-1:0] pt_pos   [PT_DEPTH];
  logic [CHAN_W-1:0] pt_red   [PT_DEPTH];
  logic [CHAN_W-1:0] pt_green [PT_DEPTH];
  logic [CHAN_W-1:0] pt_blue  [PT_DEPTH];
  int unsigned       pt_count = 0;
  logic [RS_W-1:0]   ramp_sz  = RAMP_SIZE_RESET;

  plcr_rsp_t awaited_rsp[$];
  stim_row_t dir_rows[$];
  int        mismatches = 0;
  int        cycles     = 0;
  int        sent_items = 0;
  int        burst_left = 0;

  piecewise_linear_color_ramp u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic logic [CHAN_W-1:0] clamp_unit(logic [CHAN_W-1:0] v);
    return (v > UNIT) ? CHAN_W'(UNIT) : v;
  endfunction

  // Move from cl toward cr by dl/span of the way; truncate the step once,
  // toward cl, so the result never leaves the segment.
  function automatic logic [CHAN_W-1:0] blend(int unsigned cl, int unsigned cr,
                                              int unsigned dl, int unsigned span);
    longint unsigned mag;
    if (cr >= cl) begin
      mag = (64'(cr - cl) * 64'(dl)) / 64'(span);
      return CHAN_W'(64'(cl) + mag);
    end
    mag = (64'(cl - cr) * 64'(dl)) / 64'(span);
    return CHAN_W'(64'(cl) - mag);
  endfunction

  // Apply one command to the shadow table and return the color it yields.
  function automatic plcr_rsp_t next_ramp_result(plcr_req_t r);
    plcr_rsp_t         rsp;
    int unsigned       rs;
    int unsigned       idx;
    int unsigned       u;
    int unsigned       n;
    int unsigned       dl;
    int unsigned       span;
    int unsigned       vpos [PT_DEPTH+1];
    logic [CHAN_W-1:0] vr   [PT_DEPTH+1];
    logic [CHAN_W-1:0] vg   [PT_DEPTH+1];
    logic [CHAN_W-1:0] vb   [PT_DEPTH+1];
    bit                hit;
    rsp = '0;
    case (r.mode)
      MODE_CLEAR: begin
        pt_count = 0;
      end
      MODE_APPEND: begin
        if (pt_count >= PT_DEPTH) begin
          rsp.status = STATUS_FULL;
        end else begin
          pt_pos[pt_count]   = clamp_unit(r.point_position);
          pt_red[pt_count]   = clamp_unit(r.point_red);
          pt_green[pt_count] = clamp_unit(r.point_green);
          pt_blue[pt_count]  = clamp_unit(r.point_blue);
          pt_count++;
        end
      end
      MODE_QUERY: begin
        if (pt_count == 0) begin
          rsp.status = STATUS_EMPTY;
        end else begin
          rs  = (ramp_sz < RAMP_SIZE_MIN) ? RAMP_SIZE_MIN : ramp_sz;
          idx = (r.entry_index > rs - 1) ? rs - 1 : r.entry_index;
          u   = idx * UNIT / (rs - 1);
          // Unless the first point sits at zero, pad the front with a copy of its color at position zero.
          n = 0;
          if (pt_pos[0] != 0) begin
            vpos[0] = 0;
            vr[0]   = pt_red[0];
            vg[0]   = pt_green[0];
            vb[0]   = pt_blue[0];
            n       = 1;
          end
          for (int k = 0; k < pt_count; k++) begin
            vpos[n] = pt_pos[k];
            vr[n]   = pt_red[k];
            vg[n]   = pt_green[k];
            vb[n]   = pt_blue[k];
            n++;
          end
          // Fall back to the last color unless some segment holds u.
          rsp.out_red   = vr[n-1];
          rsp.out_green = vg[n-1];
          rsp.out_blue  = vb[n-1];
          hit = 1'b0;
          for (int j = 0; j + 1 < n && !hit; j++) begin
            if (vpos[j] <= u && u < vpos[j+1]) begin
              dl            = u - vpos[j];
              span          = vpos[j+1] - vpos[j];
              rsp.out_red   = blend(vr[j], vr[j+1], dl, span);
              rsp.out_green = blend(vg[j], vg[j+1], dl, span);
              rsp.out_blue  = blend(vb[j], vb[j+1], dl, span);
              hit           = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic stim_row_t row(logic [1:0] mode, int pos, int red, int green,
                                    int blue, int idx, bit fixed,
                                    logic [1:0] st = STATUS_OK,
                                    int xr = 0, int xg = 0, int xb = 0);
    stim_row_t s;
    s.req.mode           = mode;
    s.req.point_position = CHAN_W'(pos);
    s.req.point_red      = CHAN_W'(red);
    s.req.point_green    = CHAN_W'(green);
    s.req.point_blue     = CHAN_W'(blue);
    s.req.entry_index    = IDX_W'(idx);
    s.fixed              = fixed;
    s.rsp.status         = st;
    s.rsp.out_red        = CHAN_W'(xr);
    s.rsp.out_green      = CHAN_W'(xg);
    s.rsp.out_blue       = CHAN_W'(xb);
    return s;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(stim_row_t s);
    dir_rows = {dir_rows, s};
  endfunction

  // Fill every field at random; the caller overrides what the mode uses.
  function automatic stim_row_t noise_req(logic [1:0] mode);
    stim_row_t s;
    s                    = '0;
    s.req.mode           = mode;
    s.req.point_position = CHAN_W'($urandom);
    s.req.point_red      = CHAN_W'($urandom);
    s.req.point_green    = CHAN_W'($urandom);
    s.req.point_blue     = CHAN_W'($urandom);
    s.req.entry_index    = IDX_W'($urandom);
    return s;
  endfunction

  // Q1.15 value biased toward the ends, with the odd over-range raw value.
  function automatic int unsigned unit_sample();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 0;
    if (pick == 1) return UNIT;
    if (pick == 2) return $urandom_range(0, 16'hFFFF);
    return $urandom_range(0, UNIT);
  endfunction

  // Present one command and hold it until the block takes it. The sender
  // runs in bursts; at the start of each burst it may drop start for a random gap.
  task automatic issue(stim_row_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    request       <= s.req;
    req_fixed     <= s.fixed;
    req_fixed_rsp <= s.rsp;
    start         <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_items++;
  endtask

  // Drop start and hold off until every outstanding result is back.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic set_ramp_size(int unsigned v);
    settle();
    cfg_data  <= RS_W'(v);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random sequence: mostly clear, load a table, then query it; now and
  // then overfill the table, load it out of order, or send pure noise.
  task automatic run_episode(int unsigned cur_size);
    int          kind;
    int          n;
    int unsigned idx_top;
    int unsigned spots[$];
    stim_row_t   s;
    idx_top = (cur_size < 2) ? 1 : cur_size - 1;
    if (idx_top > 4095) idx_top = 4095;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(4, 10)) issue(noise_req(2'($urandom_range(0, 3))));
      return;
    end
    n = (kind == 7) ? PT_DEPTH + $urandom_range(1, 3) : $urandom_range(1, PT_DEPTH);
    repeat (n) spots = {spots, unit_sample()};
    if (kind != 8) begin
      spots.sort();
      if ($urandom_range(0, 2) == 0) spots[0] = 0;
    end
    issue(noise_req(MODE_CLEAR));
    foreach (spots[k]) begin
      s                    = noise_req(MODE_APPEND);
      s.req.point_position = CHAN_W'(spots[k]);
      s.req.point_red      = CHAN_W'(unit_sample());
      s.req.point_green    = CHAN_W'(unit_sample());
      s.req.point_blue     = CHAN_W'(unit_sample());
      issue(s);
    end
    repeat ($urandom_range(3, 14)) begin
      s = noise_req(MODE_QUERY);
      if ($urandom_range(0, 9) < 8) s.req.entry_index = IDX_W'($urandom_range(0, idx_top));
      issue(s);
    end
    // Now and then let the pipeline run dry before the next sequence.
    if ($urandom_range(0, 7) == 0) settle();
  endtask

  // --------------------------------------------------------------------------
  // Monitor: predict on each accepted command, check each strobed result
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    plcr_rsp_t want;
    if (!rst) begin
      // Retire first: a result at this edge belongs to an older command.
      if (done) begin
        if (awaited_rsp.size() == 0) begin
          $error("result strobed with no command outstanding");
          mismatches++;
        end else begin
          want = awaited_rsp.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            mismatches++;
          end
          if (result.out_red !== want.out_red) begin
            $error("out_red: expected %0d, got %0d", want.out_red, result.out_red);
            mismatches++;
          end
          if (result.out_green !== want.out_green) begin
            $error("out_green: expected %0d, got %0d", want.out_green, result.out_green);
            mismatches++;
          end
          if (result.out_blue !== want.out_blue) begin
            $error("out_blue: expected %0d, got %0d", want.out_blue, result.out_blue);
            mismatches++;
          end
        end
      end
      // Advance the shadow table on every accepted transaction, even where
      // the row carries its own typed expectation.
      if (start && !busy) begin
        want        = next_ramp_result(request);
        awaited_rsp = {awaited_rsp, (req_fixed ? req_fixed_rsp : want)};
      end
      if (cfg_valid && cfg_ready) begin
        ramp_sz = cfg_data;
      end
    end
  end

  // Hard stop if the block hangs or loses a result.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_piecewise_linear_color_ramp: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    int unsigned sizes[$];
    int          goal;

    clk           = 1'b0;
    rst           = 1'b1;
    start         = 1'b0;
    request       = '0;
    req_fixed     = 1'b0;
    req_fixed_rsp = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part, ramp size still at its reset value of 256.
    // Empty-table query, then the unused mode with every field high.
    add_row(row(MODE_QUERY, 0, 0, 0, 0, 0, FIXED, STATUS_EMPTY));
    add_row(row(MODE_SPARE, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFF, FIXED));
    // Single point with an over-range red: every entry gives that color.
    add_row(row(MODE_APPEND, 100, 'hFFFF, 0, UNIT, 0, FIXED));
    add_row(row(MODE_QUERY, 0, 0, 0, 0, 0, FIXED, STATUS_OK, UNIT, 0, UNIT));
    add_row(row(MODE_QUERY, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFF, FIXED,
                STATUS_OK, UNIT, 0, UNIT));
    add_row(row(MODE_CLEAR, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFF, FIXED));
    // Three ordered points, first above zero, last position saturating.
    add_row(row(MODE_APPEND, 4096, 0, UNIT, 0, 0, FIXED));
    add_row(row(MODE_APPEND, 16384, UNIT, 0, 16384, 0, FIXED));
    add_row(row(MODE_APPEND, 'hFFFF, 1000, 2000, 3000, 0, FIXED));
    // Below the first point: first color; then a computed query further along.
    add_row(row(MODE_QUERY, 0, 0, 0, 0, 0, FIXED, STATUS_OK, 0, UNIT, 0));
    add_row(row(MODE_QUERY, 0, 0, 0, 0, 128, CALC));
    // At the last point, and an index past the end: last color.
    add_row(row(MODE_QUERY, 0, 0, 0, 0, 255, FIXED, STATUS_OK, 1000, 2000, 3000));
    add_row(row(MODE_QUERY, 0, 0, 0, 0, 'hFFF, FIXED, STATUS_OK, 1000, 2000, 3000));
    add_row(row(MODE_QUERY, 0, 0, 0, 0, 40, CALC));
    // Fill the table out of order, then overflow it.
    add_row(row(MODE_APPEND, 8000, 'h8001, 12345, 0, 0, FIXED));
    add_row(row(MODE_APPEND, 2000, 300, 'hFFFF, 7, 0, FIXED));
    add_row(row(MODE_APPEND, 30000, 0, 0, UNIT, 0, FIXED));
    add_row(row(MODE_APPEND, UNIT, 5, 6, 7, 0, FIXED));
    add_row(row(MODE_APPEND, 0, UNIT, UNIT, UNIT, 0, FIXED));
    add_row(row(MODE_APPEND, 500, 1, 1, 1, 0, FIXED, STATUS_FULL));
    add_row(row(MODE_QUERY, 0, 0, 0, 0, 20, CALC));
    add_row(row(MODE_QUERY, 0, 0, 0, 0, 250, CALC));
    // Clear really empties the table.
    add_row(row(MODE_CLEAR, 0, 0, 0, 0, 0, FIXED));
    add_row(row(MODE_QUERY, 0, 0, 0, 0, 7, FIXED, STATUS_EMPTY));
    add_row(row(MODE_APPEND, 0, 0, 0, 0, 0, FIXED));
    foreach (dir_rows[k]) issue(dir_rows[k]);

    // Random part: one phase per ramp size, extremes and below-minimum
    // values among them, ending back at the reset value.
    sizes = '{2, 4096, 8191, 0, 1, 33, $urandom_range(3, 600), 256};
    foreach (sizes[p]) begin
      set_ramp_size(sizes[p]);
      goal = sent_items + RAND_ITEMS / sizes.size();
      while (sent_items < goal) run_episode(sizes[p]);
    end

    // Drain, then watch a while longer for stray strobes.
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_piecewise_linear_color_ramp: clean");
    end else begin
      $display("tb_piecewise_linear_color_ramp: errors");
    end
    $finish;
  end

endmodule
